/* rtl/fwt_pkg.sv */
// Fenwick frequency table: shared constants, request codes and the
// controller-to-datapath command and status types.
// No dependencies.
package fwt_pkg;

  localparam int unsigned TreeSize = 256;
  localparam int unsigned AddrW    = $clog2(TreeSize);
  localparam int unsigned SymW     = AddrW + 1;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgW     = 9;

  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_BUILD  = 3'd2;
  localparam logic [2:0] REQ_COUNTS = 3'd3;
  localparam logic [2:0] REQ_CUM    = 3'd4;
  localparam logic [2:0] REQ_FREQ   = 3'd5;
  localparam logic [2:0] REQ_HALVE  = 3'd6;

  localparam logic CFG_ACTIVE_SIZE = 1'b0;
  localparam logic CFG_TOP_SPAN    = 1'b1;

  typedef enum logic [1:0] {
    WR_VALUE,
    WR_SUM,
    WR_DIFF,
    WR_HALF
  } wr_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic [AddrW-1:0] rd_a_addr;
    logic [AddrW-1:0] rd_b_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    wr_sel_e          wr_sel;
    acc_op_e          acc_op;
    logic             wval_load;
    logic             out_load;
    logic             out_bad;
  } fwt_cmd_t;

  typedef struct packed {
    logic out_free;
  } fwt_sts_t;

endpackage

/* rtl/fwt_dp.sv */
// Fenwick frequency table datapath: tree memory with two registered read
// ports, accumulator and result register. Depends on fwt_pkg.
module fwt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fwt_pkg::fwt_cmd_t            cmd_i,
  output fwt_pkg::fwt_sts_t            sts_o,
  input  logic [fwt_pkg::CountW-1:0]   write_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fwt_pkg::CountW-1:0]   result_value_o,
  output logic                         bad_index_o
);
  import fwt_pkg::*;

  logic [CountW-1:0] tree_mem [TreeSize];
  logic [CountW-1:0] rd_a_q, rd_b_q;
  logic [CountW-1:0] wval_q;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] wr_data;
  logic [CountW-1:0] result_value_q;
  logic              bad_q;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    case (cmd_i.wr_sel)
      WR_VALUE: wr_data = wval_q;
      WR_SUM:   wr_data = rd_a_q + rd_b_q;
      WR_DIFF:  wr_data = rd_a_q - rd_b_q;
      WR_HALF:  wr_data = rd_a_q - (rd_a_q >> 1);
      default:  wr_data = wval_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tree_mem[cmd_i.wr_addr] <= wr_data;
    end
    rd_a_q <= tree_mem[cmd_i.rd_a_addr];
    rd_b_q <= tree_mem[cmd_i.rd_b_addr];
  end

  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_CLR:  acc_d = '0;
      ACC_LOAD: acc_d = rd_a_q;
      ACC_ADD:  acc_d = acc_q + rd_a_q;
      ACC_SUB:  acc_d = acc_q - rd_a_q;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.wval_load) begin
      wval_q <= write_value_i;
    end
    if (cmd_i.out_load) begin
      result_value_q <= cmd_i.out_bad ? '0 : acc_q;
      bad_q          <= cmd_i.out_bad;
    end
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free  = ~out_valid_q | ~out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign result_value_o  = result_value_q;
  assign bad_index_o     = bad_q;

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result load did not raise out_valid");

  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && cmd_i.out_bad |=> result_value_q == '0)
    else $error("bad index result not zero");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_i.out_load)
    else $error("pending result overwritten");

endmodule

/* rtl/fwt_ctrl.sv */
// Fenwick frequency table controller: request decode, configuration
// registers and the index loops for queries and conversions. Depends on fwt_pkg.
module fwt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [fwt_pkg::SymW-1:0]   symbol_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [fwt_pkg::CfgW-1:0]   cfg_data_i,
  input  fwt_pkg::fwt_sts_t          sts_i,
  output fwt_pkg::fwt_cmd_t          cmd_o
);
  import fwt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WB,
    ST_B_OUT,
    ST_B_IN,
    ST_B_WB,
    ST_T_OUT,
    ST_T_IN,
    ST_T_WB,
    ST_H_IN,
    ST_H_WB,
    ST_C_CHK,
    ST_C_WB,
    ST_F_LOAD,
    ST_F_CHK,
    ST_F_WB,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [2:0]        req_q, req_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              bad_q, bad_d;
  logic              halve_q, halve_d;
  logic [SymW:0]     p_q, p_d;
  logic [SymW-1:0]   h_q, h_d;
  logic [SymW:0]     s_q, s_d;
  logic [SymW-1:0]   k_q, k_d;
  logic [SymW-1:0]   stop_q, stop_d;
  logic [CfgW-1:0]   active_size_q, active_size_d;
  logic [CfgW-1:0]   top_span_q, top_span_d;

  logic [SymW-1:0]   n;
  logic [SymW-1:0]   k_m1;
  logic [SymW:0]     s_m_h;
  logic              in_xfer;

  assign n = (active_size_q > CfgW'(TreeSize)) ? SymW'(TreeSize) : SymW'(active_size_q);
  assign k_m1  = k_q - 1'b1;
  assign s_m_h = s_q - {1'b0, h_q};
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  always_comb begin
    active_size_d = active_size_q;
    top_span_d    = top_span_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ACTIVE_SIZE: active_size_d = cfg_data_i;
        CFG_TOP_SPAN:    top_span_d    = cfg_data_i;
        default:         active_size_d = active_size_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    sym_d   = sym_q;
    bad_d   = bad_q;
    halve_d = halve_q;
    p_d     = p_q;
    h_d     = h_q;
    s_d     = s_q;
    k_d     = k_q;
    stop_d  = stop_q;
    cmd_o   = '{rd_a_addr: '0, rd_b_addr: '0, wr_en: 1'b0, wr_addr: '0,
                wr_sel: WR_VALUE, acc_op: ACC_HOLD, wval_load: 1'b0,
                out_load: 1'b0, out_bad: 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          req_d           = req_type_i;
          sym_d           = symbol_i;
          bad_d           = 1'b0;
          halve_d         = 1'b0;
          cmd_o.acc_op    = ACC_CLR;
          cmd_o.wval_load = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (req_q)
          REQ_WRITE: begin
            bad_d = (sym_q >= SymW'(TreeSize));
            if (sym_q < SymW'(TreeSize)) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = sym_q[AddrW-1:0];
              cmd_o.wr_sel  = WR_VALUE;
            end
            state_d = ST_FIN;
          end
          REQ_READ: begin
            if (sym_q >= SymW'(TreeSize)) begin
              bad_d   = 1'b1;
              state_d = ST_FIN;
            end else begin
              cmd_o.rd_a_addr = sym_q[AddrW-1:0];
              state_d         = ST_READ_WB;
            end
          end
          REQ_BUILD: begin
            h_d     = SymW'(1);
            p_d     = (SymW+1)'(2);
            state_d = ST_B_OUT;
          end
          REQ_COUNTS, REQ_HALVE: begin
            p_d     = {1'b0, top_span_q};
            halve_d = (req_q == REQ_HALVE);
            state_d = ST_T_OUT;
          end
          REQ_CUM: begin
            if (sym_q > n) begin
              bad_d   = 1'b1;
              state_d = ST_FIN;
            end else begin
              k_d     = sym_q;
              state_d = ST_C_CHK;
            end
          end
          REQ_FREQ: begin
            if (sym_q >= n) begin
              bad_d   = 1'b1;
              state_d = ST_FIN;
            end else begin
              k_d             = sym_q;
              stop_d          = sym_q & (sym_q + 1'b1);
              cmd_o.rd_a_addr = sym_q[AddrW-1:0];
              state_d         = ST_F_LOAD;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_READ_WB: begin
        cmd_o.acc_op = ACC_LOAD;
        state_d      = ST_FIN;
      end
      ST_B_OUT: begin
        if (p_q <= {1'b0, n}) begin
          s_d     = p_q - 1'b1;
          state_d = ST_B_IN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_B_IN: begin
        if (s_q < {1'b0, n}) begin
          cmd_o.rd_a_addr = s_q[AddrW-1:0];
          cmd_o.rd_b_addr = s_m_h[AddrW-1:0];
          state_d         = ST_B_WB;
        end else begin
          h_d     = p_q[SymW-1:0];
          p_d     = p_q << 1;
          state_d = ST_B_OUT;
        end
      end
      ST_B_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = s_q[AddrW-1:0];
        cmd_o.wr_sel  = WR_SUM;
        s_d           = s_q + p_q;
        state_d       = ST_B_IN;
      end
      ST_T_OUT: begin
        if (p_q > (SymW+1)'(1)) begin
          h_d     = p_q[SymW:1];
          s_d     = p_q - 1'b1;
          state_d = ST_T_IN;
        end else if (halve_q) begin
          s_d     = '0;
          state_d = ST_H_IN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_T_IN: begin
        if (s_q < {1'b0, n}) begin
          cmd_o.rd_a_addr = s_q[AddrW-1:0];
          cmd_o.rd_b_addr = s_m_h[AddrW-1:0];
          state_d         = ST_T_WB;
        end else begin
          p_d     = {1'b0, h_q};
          state_d = ST_T_OUT;
        end
      end
      ST_T_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = s_q[AddrW-1:0];
        cmd_o.wr_sel  = WR_DIFF;
        s_d           = s_q + p_q;
        state_d       = ST_T_IN;
      end
      ST_H_IN: begin
        if (s_q < {1'b0, n}) begin
          cmd_o.rd_a_addr = s_q[AddrW-1:0];
          state_d         = ST_H_WB;
        end else begin
          h_d     = SymW'(1);
          p_d     = (SymW+1)'(2);
          state_d = ST_B_OUT;
        end
      end
      ST_H_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = s_q[AddrW-1:0];
        cmd_o.wr_sel  = WR_HALF;
        s_d           = s_q + 1'b1;
        state_d       = ST_H_IN;
      end
      ST_C_CHK: begin
        if (k_q != '0) begin
          cmd_o.rd_a_addr = k_m1[AddrW-1:0];
          state_d         = ST_C_WB;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_C_WB: begin
        cmd_o.acc_op = ACC_ADD;
        k_d          = k_q & k_m1;
        state_d      = ST_C_CHK;
      end
      ST_F_LOAD: begin
        cmd_o.acc_op = ACC_LOAD;
        state_d      = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (k_q != stop_q) begin
          cmd_o.rd_a_addr = k_m1[AddrW-1:0];
          state_d         = ST_F_WB;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_F_WB: begin
        cmd_o.acc_op = ACC_SUB;
        k_d          = k_q & k_m1;
        state_d      = ST_F_CHK;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_bad  = bad_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      req_q         <= '0;
      sym_q         <= '0;
      bad_q         <= 1'b0;
      halve_q       <= 1'b0;
      p_q           <= '0;
      h_q           <= '0;
      s_q           <= '0;
      k_q           <= '0;
      stop_q        <= '0;
      active_size_q <= CfgW'(TreeSize);
      top_span_q    <= CfgW'(TreeSize);
    end else begin
      state_q       <= state_d;
      req_q         <= req_d;
      sym_q         <= sym_d;
      bad_q         <= bad_d;
      halve_q       <= halve_d;
      p_q           <= p_d;
      h_q           <= h_d;
      s_q           <= s_d;
      k_q           <= k_d;
      stop_q        <= stop_d;
      active_size_q <= active_size_d;
      top_span_q    <= top_span_d;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_DECODE)
    else $error("accepted request not decoded");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded into a busy output register");

  a_loop_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en && state_q != ST_DECODE |-> {1'b0, cmd_o.wr_addr} < n)
    else $error("tree loop wrote beyond active size");

endmodule

/* rtl/fenwick_frequency_table_core.sv */
// Fenwick frequency table top level: joins controller and datapath.
// Depends on fwt_pkg, fwt_ctrl and fwt_dp.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  request  | in        | in_valid_i/in_stall_o   | req_type_i, symbol_i, write_value_i
//  result   | out       | out_valid_o/out_stall_i | result_value_o, bad_index_o
//  config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Cumulative queries add up to 8 tree entries, frequency queries visit up to 9
// tree entries. Build and to-counts update entries level by level; halving runs
// to-counts, halves every active symbol's count, then builds again. Each build or
// to-counts entry step is a two-port memory read then a write-back. One request
// is in flight at a time; the result register lets the next request transfer
// while a result waits. No clearing pass after reset.
module fenwick_frequency_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [fwt_pkg::SymW-1:0]     symbol_i,
  input  logic [fwt_pkg::CountW-1:0]   write_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fwt_pkg::CountW-1:0]   result_value_o,
  output logic                         bad_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [fwt_pkg::CfgW-1:0]     cfg_data_i
);
  import fwt_pkg::*;

  fwt_cmd_t cmd;
  fwt_sts_t sts;

  fwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .symbol_i    (symbol_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fwt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .bad_index_o    (bad_index_o)
  );

endmodule
